// File: hw/rtl/bclp_pkg.sv
// ----------------------------------------------------------------------------
// bclp_pkg
// Shared types and constants for the button click / long-press detector.
// ----------------------------------------------------------------------------
package bclp_pkg;

    localparam int TIMER_WIDTH_DEF = 16;

    localparam int DEB_W  = 8;
    localparam int LONG_W = 16;
    localparam int CLK_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(2);
    localparam logic [LONG_W-1:0] LONG_RST     = LONG_W'(100);
    localparam logic [CLK_W-1:0]  CLICK_RST    = CLK_W'(5);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_CLICK    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2,
        PH_WAIT_REL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_SINGLE   = 2'd1,
        ACT_LONG     = 2'd2,
        ACT_LONG_REL = 2'd3
    } action_t;

endpackage

// File: hw/rtl/button_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// button_click_long_press_detector
// Debounces a polled active-low button and reports single click, long press
// and long release events, one result per poll tick.
// ----------------------------------------------------------------------------
//  channel   dir   width  content
//  s_axis    in    8      pin_level [0]
//  m_axis    out   8      action_code [1:0], phase [3:2]
//  cfg       in    16     debounce / long press / click timeout registers
//
//  One tick per cycle unless stalled: state update and result are computed
//  in one pass from the state registers and land in the output register.
//  aresetn is synchronous, active low; clears state, loads config defaults.
//  A stalled output holds; a new tick is still taken whenever the output
//  register is empty or being drained in the same cycle.
module button_click_long_press_detector #(
    parameter int TIMER_WIDTH = bclp_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] pin_level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [1:0] action_code, [3:2] phase
    input  logic                            cfg_we,
    input  logic [bclp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bclp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TW = TIMER_WIDTH;
    localparam int CW = (TW > bclp_pkg::LONG_W) ? TW : bclp_pkg::LONG_W;

    logic [bclp_pkg::DEB_W-1:0]  debounce_reg;
    logic [bclp_pkg::LONG_W-1:0] long_press_reg;
    logic [bclp_pkg::CLK_W-1:0]  click_timeout_reg;

    bclp_pkg::phase_t phase_reg, phase_next;
    logic             last_pressed_reg, last_pressed_next;
    logic [TW-1:0]    stable_reg, stable_next;
    logic [TW-1:0]    held_reg, held_next;
    logic [TW-1:0]    since_reg, since_next;
    logic             pending_reg, pending_next;
    logic             long_fired_reg, long_fired_next;
    bclp_pkg::action_t action_next;

    logic             m_valid_reg;
    logic [1:0]       m_action_reg;
    logic [1:0]       m_phase_reg;
    logic             s_xfer;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_phase_reg, m_action_reg};

    // Configuration registers; unknown index is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg      <= bclp_pkg::DEBOUNCE_RST;
            long_press_reg    <= bclp_pkg::LONG_RST;
            click_timeout_reg <= bclp_pkg::CLICK_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                bclp_pkg::REG_DEBOUNCE: begin
                    debounce_reg <= cfg_wdata[bclp_pkg::DEB_W-1:0];
                end
                bclp_pkg::REG_LONG: begin
                    long_press_reg <= cfg_wdata[bclp_pkg::LONG_W-1:0];
                end
                bclp_pkg::REG_CLICK: begin
                    click_timeout_reg <= cfg_wdata[bclp_pkg::CLK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic pressed;
        logic stable_ok;
        pressed = !s_tdata[0];

        phase_next      = phase_reg;
        pending_next    = pending_reg;
        long_fired_next = long_fired_reg;
        action_next     = bclp_pkg::ACT_NONE;

        // advance the saturating timers
        held_next  = (held_reg == '1)  ? held_reg  : held_reg + 1'b1;
        since_next = (since_reg == '1) ? since_reg : since_reg + 1'b1;

        // a change of pressed sense restarts the stable count
        if (pressed != last_pressed_reg) begin
            stable_next = '0;
        end else begin
            stable_next = (stable_reg == '1) ? stable_reg : stable_reg + 1'b1;
        end
        last_pressed_next = pressed;

        stable_ok = CW'(stable_next) >= CW'(debounce_reg);

        if (stable_ok) begin
            if (phase_reg == bclp_pkg::PH_IDLE && pressed) begin
                held_next       = '0;
                long_fired_next = 1'b0;
                // second press inside the click window cancels silently
                if (pending_reg) begin
                    pending_next = 1'b0;
                end else begin
                    pending_next = 1'b1;
                    phase_next   = bclp_pkg::PH_PRESSED;
                end
            end else if (phase_reg == bclp_pkg::PH_PRESSED && !pressed) begin
                since_next = '0;
                phase_next = long_fired_reg ? bclp_pkg::PH_RELEASED : bclp_pkg::PH_IDLE;
            end else if (phase_reg == bclp_pkg::PH_WAIT_REL && !pressed) begin
                action_next     = bclp_pkg::ACT_LONG_REL;
                phase_next      = bclp_pkg::PH_IDLE;
                pending_next    = 1'b0;
                long_fired_next = 1'b0;
                held_next       = '0;
                since_next      = '0;
            end
        end

        if (phase_next == bclp_pkg::PH_PRESSED && !long_fired_next &&
            CW'(held_next) >= CW'(long_press_reg)) begin
            long_fired_next = 1'b1;
            pending_next    = 1'b0;
            action_next     = bclp_pkg::ACT_LONG;
            phase_next      = bclp_pkg::PH_WAIT_REL;
        end

        if (phase_next == bclp_pkg::PH_IDLE && pending_next &&
            CW'(since_next) >= CW'(click_timeout_reg)) begin
            action_next     = bclp_pkg::ACT_SINGLE;
            phase_next      = bclp_pkg::PH_IDLE;
            pending_next    = 1'b0;
            long_fired_next = 1'b0;
            held_next       = '0;
            since_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= bclp_pkg::PH_IDLE;
            last_pressed_reg <= 1'b0;
            stable_reg       <= '0;
            held_reg         <= '0;
            since_reg        <= '0;
            pending_reg      <= 1'b0;
            long_fired_reg   <= 1'b0;
        end else if (s_xfer) begin
            phase_reg        <= phase_next;
            last_pressed_reg <= last_pressed_next;
            stable_reg       <= stable_next;
            held_reg         <= held_next;
            since_reg        <= since_next;
            pending_reg      <= pending_next;
            long_fired_reg   <= long_fired_next;
        end
    end

    // Output register: load on an input transfer, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_action_reg <= action_next;
            m_phase_reg  <= phase_next;
        end
    end

    a_no_released_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != bclp_pkg::PH_RELEASED)
        else $error("detector entered released phase");

    a_long_means_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        long_fired_reg |-> (phase_reg == bclp_pkg::PH_WAIT_REL && !pending_reg))
        else $error("long press flag outside waiting-release phase");

    a_long_out_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_action_reg == bclp_pkg::ACT_LONG)
            |-> m_phase_reg == bclp_pkg::PH_WAIT_REL)
        else $error("long press reported without waiting-release phase");

    a_end_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_action_reg == bclp_pkg::ACT_SINGLE ||
                         m_action_reg == bclp_pkg::ACT_LONG_REL))
            |-> m_phase_reg == bclp_pkg::PH_IDLE)
        else $error("click or long release reported outside idle phase");

endmodule
